@@ rtl/scfba_pkg.sv @@
package scfba_pkg;

	localparam int MAP_WORDS  = 64;
	localparam int WORD_AW    = $clog2(MAP_WORDS);
	localparam int CFG_W      = 7;
	localparam int PAGE_SHIFT = 12;
	localparam int FRAME_W    = 32 - PAGE_SHIFT;
	localparam int FLAGS_W    = 12;
	localparam int COUNT_W    = 4;
	localparam int REGION_W   = 8;

	localparam logic [CFG_W-1:0] WORDS_RESET = CFG_W'(MAP_WORDS);

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RESERVE = 2'd1;
	localparam logic [1:0] OP_FREE    = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       scan;
		logic       rd0;
		logic       wr0;
		logic       rd1;
		logic       wr1;
		logic       emit_frames;
		logic       emit_one;
		logic [1:0] one_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trivial;
		logic is_alloc;
		logic is_reserve;
		logic range_bad;
		logic lim_zero;
		logic hit;
		logic exhausted;
		logic spans;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

@@ rtl/size_class_frame_bitmap_allocator.sv @@
// Page-frame allocator over a 64-word used-frame bitmap (one bit per 4 KiB frame), all free
// after reset. Each request gives its results in order with tlast on the final one: an
// allocate or reserve that succeeds gives one frame address (ORed with the flags) per frame,
// and every other outcome gives one result with a zero address and a status. An allocate
// reads the bitmap one word per cycle from word 0 and stops at the first word with a free
// run in the class region, or answers out of memory after the last word in use. A reserve or
// free reads and rewrites the word of its first frame, and the next word if the range spans
// it. The single bitmap read port paces the scan. One request is handled at a time, and the
// next request is accepted once the last result of the previous one sits in the output
// register. The user must write words_in_use only while idle; the block does not enforce it.
module size_class_frame_bitmap_allocator
	import scfba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // count[3:0], address[35:4], flags[47:36]
	input  logic [1:0]        s_axis_tuser,  // op[1:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,  // frame_address[31:0]
	output logic [1:0]        m_axis_tuser,  // status[1:0]
	output logic              m_axis_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	scfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scfba_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_tdata      (s_axis_tdata),
		.in_tuser      (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// A failed request is always a single, final result.
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> m_axis_tlast)
		else $error("error result without tlast");

	// A failed request never carries a frame address.
	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 32'd0))
		else $error("error result with nonzero address");

	// After a request is taken, the block is busy in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while previous one in progress");
`endif

endmodule

@@ rtl/scfba_dpath.sv @@
module scfba_dpath
	import scfba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [47:0]          in_tdata,
	input  logic [1:0]           in_tuser,
	input  logic                 cfg_valid,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,
	output logic [1:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	// Request registers
	logic [1:0]           op_q;
	logic [COUNT_W-1:0]   n_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [FLAGS_W-1:0]   flags_q;
	logic [COUNT_W-1:0]   idx_q;
	logic [CFG_W-1:0]     words_q;
	logic [CFG_W-1:0]     lim;

	// Bitmap memory with one valid bit per word; a word never written reads as zero.
	logic [31:0]          mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] wvalid_q;
	logic [31:0]          raw_s1;
	logic                 rbit_s1;
	logic [31:0]          word_s1;
	logic [WORD_AW-1:0]   raddr;
	logic [WORD_AW-1:0]   waddr;
	logic [31:0]          wdata;
	logic                 we;

	// Scan pointers
	logic [CFG_W-1:0]     wptr_q;
	logic                 rd_vld_s1;
	logic [WORD_AW-1:0]   rd_word_s1;
	logic                 issue;

	// Range helpers
	logic [FRAME_W:0]     lastf;
	logic [WORD_AW-1:0]   w0;
	logic [7:0]           nmask;
	logic [39:0]          span_mask;

	// Allocation search
	logic [4:0]           base;
	logic                 found;
	logic [31:0]          sel_mask;
	logic [4:0]           sel_start;

	logic                 out_vld_q;
	logic [31:0]          out_data_q;
	logic [1:0]           out_st_q;
	logic                 out_last_q;

	logic [COUNT_W-1:0]   in_count;
	logic [COUNT_W-1:0]   in_n;

	assign in_count = in_tdata[3:0];
	assign in_n     = (in_count > COUNT_W'(8)) ? COUNT_W'(8) : in_count;

	assign lim = (words_q > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS) : words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= WORDS_RESET;
		end else if (cfg_valid) begin
			words_q <= cfg_data;
		end
	end

	assign nmask     = 8'((9'd1 << n_q) - 9'd1);
	assign span_mask = {32'd0, nmask} << frame_q[4:0];
	assign lastf     = {1'b0, frame_q} + (FRAME_W+1)'(n_q) - (FRAME_W+1)'(1);
	assign w0        = frame_q[5 +: WORD_AW];

	always_comb begin
		if (n_q == COUNT_W'(1))
			base = 5'd0;
		else if (n_q == COUNT_W'(2))
			base = 5'd8;
		else if (n_q <= COUNT_W'(4))
			base = 5'd16;
		else
			base = 5'd24;
	end

	// Candidate runs sit at offsets 0, n, 2n ... within the region; the lowest free one wins.
	always_comb begin
		logic [6:0]  off;
		logic [5:0]  shamt;
		logic [31:0] m;
		found     = 1'b0;
		sel_mask  = 32'd0;
		sel_start = 5'd0;
		for (int j = REGION_W - 1; j >= 0; j--) begin
			off   = 7'(j) * 7'(n_q);
			shamt = 6'(base) + off[5:0];
			m     = 32'(nmask) << shamt[4:0];
			if ((off + 7'(n_q) <= 7'(REGION_W)) && ((word_s1 & m) == 32'd0)) begin
				found     = 1'b1;
				sel_mask  = m;
				sel_start = shamt[4:0];
			end
		end
	end

	assign issue = cmd.scan && (wptr_q < lim);

	always_comb begin
		priority if (cmd.rd1)
			raddr = w0 + WORD_AW'(1);
		else if (cmd.rd0)
			raddr = w0;
		else
			raddr = wptr_q[WORD_AW-1:0];
	end

	always_comb begin
		we    = 1'b0;
		waddr = w0;
		wdata = word_s1;
		priority if (sts.hit) begin
			we    = 1'b1;
			waddr = rd_word_s1;
			wdata = word_s1 | sel_mask;
		end else if (cmd.wr0) begin
			we    = 1'b1;
			waddr = w0;
			wdata = (op_q == OP_RESERVE) ? (word_s1 | span_mask[31:0])
				: (word_s1 & ~span_mask[31:0]);
		end else if (cmd.wr1) begin
			we    = 1'b1;
			waddr = w0 + WORD_AW'(1);
			wdata = (op_q == OP_RESERVE) ? (word_s1 | {24'd0, span_mask[39:32]})
				: (word_s1 & ~{24'd0, span_mask[39:32]});
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		raw_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rbit_s1  <= 1'b0;
		end else begin
			if (we)
				wvalid_q[waddr] <= 1'b1;
			rbit_s1 <= wvalid_q[raddr];
		end
	end

	assign word_s1 = rbit_s1 ? raw_s1 : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.load)
				wptr_q <= '0;
			else if (issue)
				wptr_q <= wptr_q + CFG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		rd_word_s1 <= wptr_q[WORD_AW-1:0];
		if (cmd.load) begin
			op_q    <= in_tuser;
			n_q     <= in_n;
			frame_q <= in_tdata[4 + PAGE_SHIFT +: FRAME_W];
			flags_q <= in_tdata[36 +: FLAGS_W];
		end else if (sts.hit) begin
			frame_q <= FRAME_W'({rd_word_s1, sel_start});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.emit_frames && sts.out_free) begin
			idx_q <= idx_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (sts.out_free) begin
			out_vld_q <= cmd.emit_frames || cmd.emit_one;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.out_free) begin
			if (cmd.emit_frames) begin
				out_data_q <= {frame_q + FRAME_W'(idx_q), flags_q};
				out_st_q   <= ST_OK;
				out_last_q <= sts.emit_last;
			end else if (cmd.emit_one) begin
				out_data_q <= 32'd0;
				out_st_q   <= cmd.one_status;
				out_last_q <= 1'b1;
			end
		end
	end

	assign sts.trivial    = (n_q == '0) || (op_q == OP_NONE);
	assign sts.is_alloc   = (op_q == OP_ALLOC);
	assign sts.is_reserve = (op_q == OP_RESERVE);
	assign sts.range_bad  = (lastf[FRAME_W:5] >= (FRAME_W - 4)'(lim));
	assign sts.lim_zero   = (lim == '0);
	assign sts.hit        = cmd.scan && rd_vld_s1 && found;
	assign sts.exhausted  = rd_vld_s1 && !found
		&& ({1'b0, rd_word_s1} == (lim - CFG_W'(1)));
	assign sts.spans      = (span_mask[39:32] != 8'd0);
	assign sts.out_free   = !out_vld_q || m_axis_tready;
	assign sts.emit_last  = (idx_q == (n_q - COUNT_W'(1)));

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/scfba_ctrl.sv @@
module scfba_ctrl
	import scfba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_RD0    = 4'd3;
	localparam logic [3:0] S_WR0    = 4'd4;
	localparam logic [3:0] S_RD1    = 4'd5;
	localparam logic [3:0] S_WR1    = 4'd6;
	localparam logic [3:0] S_FRAMES = 4'd7;
	localparam logic [3:0] S_ONE    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] res_q;
	logic [1:0] res_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d         = state_q;
		res_d           = res_q;
		cmd             = '0;
		cmd.one_status  = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (sts.trivial) begin
					res_d   = ST_OK;
					state_d = S_ONE;
				end else if (sts.is_alloc && sts.lim_zero) begin
					res_d   = ST_NOMEM;
					state_d = S_ONE;
				end else if (sts.is_alloc) begin
					state_d = S_SCAN;
				end else if (sts.range_bad) begin
					res_d   = ST_RANGE;
					state_d = S_ONE;
				end else begin
					state_d = S_RD0;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (sts.hit) begin
					state_d = S_FRAMES;
				end else if (sts.exhausted) begin
					res_d   = ST_NOMEM;
					state_d = S_ONE;
				end
			end
			S_RD0: begin
				cmd.rd0 = 1'b1;
				state_d = S_WR0;
			end
			S_WR0, S_WR1: begin
				cmd.wr0 = (state_q == S_WR0);
				cmd.wr1 = (state_q == S_WR1);
				priority if ((state_q == S_WR0) && sts.spans) begin
					state_d = S_RD1;
				end else if (sts.is_reserve) begin
					state_d = S_FRAMES;
				end else begin
					res_d   = ST_OK;
					state_d = S_ONE;
				end
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_WR1;
			end
			S_FRAMES: begin
				cmd.emit_frames = 1'b1;
				if (sts.out_free && sts.emit_last)
					state_d = S_IDLE;
			end
			S_ONE: begin
				cmd.emit_one = 1'b1;
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

@@ tb/sv/size_class_frame_bitmap_allocator_tb.sv @@
`timescale 1ns / 1ps

module size_class_frame_bitmap_allocator_tb;
	import scfba_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 120;
	localparam longint RUN_LIMIT_NS = 2_000_000;
	localparam int ITEMS_PER_PHASE = 15;

	typedef struct packed {
		logic [31:0] frame_address;
		logic [1:0]  status;
		logic        last;
	} frame_result_t;

	class alloc_scoreboard;
		logic [31:0]      used_map [MAP_WORDS];
		logic [CFG_W-1:0] words_in_use;
		frame_result_t    expected_frames [$];
		int               errors;
		int               requests;
		int               checked;
		int               nomem_count;
		int               range_count;

		function void clear();
			foreach (used_map[i])
				used_map[i] = '0;
			words_in_use = WORDS_RESET;
			expected_frames.delete();
			errors = 0;
			requests = 0;
			checked = 0;
			nomem_count = 0;
			range_count = 0;
		endfunction

		function int unsigned active_words();
			return (words_in_use > MAP_WORDS) ? MAP_WORDS : words_in_use;
		endfunction

		function void push_single(logic [1:0] status);
			frame_result_t r;
			r.frame_address = '0;
			r.status = status;
			r.last = 1'b1;
			expected_frames.push_back(r);
			if (status == ST_NOMEM)
				nomem_count++;
			if (status == ST_RANGE)
				range_count++;
		endfunction

		function void push_frames(int unsigned first, int unsigned n, logic [11:0] flags);
			frame_result_t r;
			for (int unsigned i = 0; i < n; i++) begin
				r.frame_address = (32'(first + i) << PAGE_SHIFT) | 32'(flags);
				r.status = ST_OK;
				r.last = (i == n - 1);
				expected_frames.push_back(r);
			end
		endfunction

		// Updates the bitmap copy and queues the results of one accepted request.
		function void note_request(logic [1:0] op, logic [3:0] count, logic [31:0] address,
				logic [11:0] flags);
			int unsigned n, lim, cls, base, start, first, f;
			logic [31:0] region, run;
			requests++;
			n = (count > 8) ? 8 : count;
			lim = active_words();
			if (n == 0 || op == OP_NONE) begin
				push_single(ST_OK);
				return;
			end
			if (op == OP_ALLOC) begin
				cls = (n <= 1) ? 0 : (n <= 2) ? 1 : (n <= 4) ? 2 : 3;
				base = REGION_W * cls;
				region = 32'hFF << base;
				for (int unsigned w = 0; w < lim; w++) begin
					if (used_map[w] != 32'hFFFF_FFFF && (used_map[w] & region) != region) begin
						for (start = base; start + n <= base + REGION_W; start += n) begin
							run = ((32'd1 << n) - 32'd1) << start;
							if ((used_map[w] & run) == 32'd0) begin
								used_map[w] |= run;
								push_frames(w * 32 + start, n, flags);
								return;
							end
						end
					end
				end
				push_single(ST_NOMEM);
				return;
			end
			first = address >> PAGE_SHIFT;
			if (((first + n - 1) >> 5) >= lim) begin
				push_single(ST_RANGE);
				return;
			end
			for (int unsigned i = 0; i < n; i++) begin
				f = first + i;
				used_map[f >> 5][f & 31] = (op == OP_RESERVE);
			end
			if (op == OP_RESERVE)
				push_frames(first, n, flags);
			else
				push_single(ST_OK);
		endfunction

		function void check_result(logic [31:0] frame_address, logic [1:0] status,
				logic last);
			frame_result_t want;
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: unexpected result addr=%h status=%0d last=%0b", $time,
					frame_address, status, last);
				return;
			end
			want = expected_frames.pop_front();
			checked++;
			if (frame_address !== want.frame_address) begin
				errors++;
				$display("%0t: frame_address mismatch, expected %h, got %h", $time,
					want.frame_address, frame_address);
			end
			if (status !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, got %0d", $time,
					want.status, status);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: tlast mismatch, expected %0b, got %0b", $time,
					want.last, last);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [47:0]      s_axis_tdata = '0;
	logic [1:0]       s_axis_tuser = OP_NONE;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [31:0]      m_axis_tdata;
	logic [1:0]       m_axis_tuser;
	logic             m_axis_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	alloc_scoreboard sb;
	logic hold_output = 1'b0;
	logic rx_stalls = 1'b1;
	logic tx_gaps = 1'b1;

	size_class_frame_bitmap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("FAILURE");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int sender_gap();
		if (!tx_gaps || $urandom_range(0, 1) == 0)
			return 0;
		return pick_gap();
	endfunction

	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_output = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// With gap zero tvalid stays high, so the caller must offer the next request right away.
	task automatic send_request(logic [1:0] op, logic [3:0] count, logic [31:0] address,
			logic [11:0] flags, int gap);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {flags, address, count};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(op, count, address, flags);
		if (gap != 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_words(logic [CFG_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.words_in_use = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Addresses mostly land in the low words, where allocations are placed first.
	function automatic logic [31:0] random_address();
		int unsigned lim, w;
		lim = sb.active_words();
		if (lim == 0 || $urandom_range(0, 9) == 0)
			return $urandom;
		if ($urandom_range(0, 9) < 8)
			w = $urandom_range(0, ((lim < 4) ? lim : 4) - 1);
		else
			w = $urandom_range(0, lim - 1);
		return (32'(w * 32 + $urandom_range(0, 31)) << PAGE_SHIFT) |
			32'($urandom_range(0, 4095));
	endfunction

	task automatic random_request(int gap);
		logic [1:0] op;
		logic [3:0] count;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		op = (pick < 45) ? OP_ALLOC : (pick < 65) ? OP_RESERVE :
			(pick < 95) ? OP_FREE : OP_NONE;
		pick = $urandom_range(0, 99);
		count = (pick < 90) ? 4'($urandom_range(1, 8)) :
			(pick < 95) ? 4'd0 : 4'($urandom_range(9, 15));
		send_request(op, count, random_address(), 12'($urandom), gap);
	endtask

	initial begin
		logic [CFG_W-1:0] phase_words [5];
		sb = new;
		sb.clear();
		phase_words = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd5};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Allocations in every size class, starting from an empty map.
		send_request(OP_ALLOC, 4'd1, 32'h0, 12'hFFF, 1);
		send_request(OP_ALLOC, 4'd2, 32'h0, 12'h000, 0);
		send_request(OP_ALLOC, 4'd3, 32'hFFFF_FFFF, 12'h555, 1);
		send_request(OP_ALLOC, 4'd8, 32'h0, 12'hABC, 2);
		send_request(OP_ALLOC, 4'd5, 32'h0, 12'h000, 1);
		send_request(OP_ALLOC, 4'd4, 32'h0, 12'h800, 0);
		send_request(OP_ALLOC, 4'd7, 32'h0, 12'h001, 1);
		// Reserve and free across a word boundary, reserve of used frames.
		send_request(OP_RESERVE, 4'd8, (32'd60 << PAGE_SHIFT) | 32'h123, 12'h0F0, 1);
		send_request(OP_RESERVE, 4'd2, 32'h0, 12'h00F, 1);
		send_request(OP_FREE, 4'd4, 32'd62 << PAGE_SHIFT, 12'hFFF, 3);
		send_request(OP_FREE, 4'd0, 32'h0, 12'h000, 1);
		send_request(OP_NONE, 4'd3, 32'h0000_5000, 12'h123, 1);
		// A count above eight saturates.
		send_request(OP_RESERVE, 4'd15, 32'd100 << PAGE_SHIFT, 12'h7FF, 1);
		send_request(OP_RESERVE, 4'd8, 32'hFFFF_F000, 12'hFFF, 1);
		send_request(OP_RESERVE, 4'd1, (32'd2047 << PAGE_SHIFT) | 32'hFFF, 12'h3C3, 1);
		send_request(OP_FREE, 4'd8, 32'd2044 << PAGE_SHIFT, 12'h000, 1);
		send_request(OP_FREE, 4'd1, 32'd2047 << PAGE_SHIFT, 12'h000, 1);
		send_request(OP_FREE, 4'd15, 32'h0, 12'h000, 1);

		// With no words in use nothing can be allocated, reserved or freed.
		write_words(7'd0);
		send_request(OP_ALLOC, 4'd1, 32'h0, 12'h001, 1);
		send_request(OP_RESERVE, 4'd1, 32'h0, 12'h002, 0);
		send_request(OP_FREE, 4'd1, 32'h0, 12'h004, 1);

		foreach (phase_words[p]) begin
			write_words(phase_words[p]);
			rx_stalls = (p != 2);
			tx_gaps = (p != 2);
			if (p == 0) begin
				// Back-to-back large allocations while the output side is held off.
				hold_output = 1'b1;
				repeat (6)
					send_request(OP_ALLOC, 4'($urandom_range(5, 8)), 32'h0,
						12'($urandom), 0);
			end
			repeat (ITEMS_PER_PHASE)
				random_request(sender_gap());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d requests over six map sizes; %0d results checked.",
			sb.requests, sb.checked);
		$display("Out-of-frames answers: %0d, beyond-range answers: %0d, errors: %0d.",
			sb.nomem_count, sb.range_count, sb.errors);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ size_class_frame_bitmap_allocator.f @@
rtl/scfba_pkg.sv
rtl/scfba_dpath.sv
rtl/scfba_ctrl.sv
rtl/size_class_frame_bitmap_allocator.sv
tb/sv/size_class_frame_bitmap_allocator_tb.sv
